>>> rtl/imh_pkg.sv
`default_nettype none
package imh_pkg;

    localparam int VERTEX_W     = 10;
    localparam int VERTEX_CNT   = 1024;
    localparam int IN_KEY_W     = 31;
    localparam int COST_W       = 31;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 11;
    localparam int REQ_W        = 2;

    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_req REQ_INSERT   = 2'd0;
    localparam t_req REQ_EXTRACT  = 2'd1;
    localparam t_req REQ_DECREASE = 2'd2;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_EMPTY       = 3'd1;
    localparam t_status ST_FULL        = 3'd2;
    localparam t_status ST_NOT_SMALLER = 3'd3;
    localparam t_status ST_DUPLICATE   = 3'd4;

    localparam logic [COST_W-1:0] COST_EMPTY = 31'h7FFF_FFFF;

endpackage
`default_nettype wire

>>> rtl/imh_ram.sv
`default_nettype none
module imh_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/indexed_min_heap.sv
`default_nettype none
// channel   direction  handshake                     fields
// request   in         i_in_valid / o_in_stall       req_type vertex_id priority_key entry_cost
// result    out        o_out_valid / i_out_stall     status min_vertex min_key min_cost entry_count
//
// one request at a time; insert looks up the vertex map and sifts up, decrease also
// checks the stored key first; extract takes the root, moves the last entry to the root
// and sifts down when entries remain; the input is stalled until the next idle
// after reset the vertex map is swept absent, with the request stalled
// a finished result waits in the output register while the next request starts; a
// second one waits in the done state, which keeps the request side stalled
// synchronous active-low reset clears control state only
module indexed_min_heap #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 31
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [9:0]  i_vertex_id,
    input  wire logic [30:0] i_priority_key,
    input  wire logic [30:0] i_entry_cost,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [9:0]       o_min_vertex,
    output logic [30:0]      o_min_key,
    output logic [30:0]      o_min_cost,
    output logic [10:0]      o_entry_count
);

    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int VW     = imh_pkg::VERTEX_W;
    localparam int CSW    = imh_pkg::COST_W;
    localparam int SDW    = VW + KEY_WIDTH + CSW;
    localparam int MDW    = 1 + AW;
    localparam int MAW    = $clog2(imh_pkg::VERTEX_CNT);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAP   = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_UP    = 4'd3;
    localparam logic [3:0] S_UPCHK = 4'd4;
    localparam logic [3:0] S_ROOT  = 4'd5;
    localparam logic [3:0] S_LAST  = 4'd6;
    localparam logic [3:0] S_DN    = 4'd7;
    localparam logic [3:0] S_DNL   = 4'd8;
    localparam logic [3:0] S_DNR   = 4'd9;
    localparam logic [3:0] S_DNMV  = 4'd10;
    localparam logic [3:0] S_PLACE = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]          r_state;
    logic                r_clr_busy;
    logic [MAW-1:0]      r_clr_idx;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_pos;
    logic [SDW-1:0]      r_mov;
    logic [SDW-1:0]      r_best;
    logic [AW-1:0]       r_best_idx;
    logic [1:0]          r_type;
    logic [VW-1:0]       r_vid;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CSW-1:0]      r_cost;
    logic [2:0]          r_res_status;
    logic [VW-1:0]       r_res_vertex;
    logic [KEY_WIDTH-1:0] r_res_key;
    logic [CSW-1:0]      r_res_cost;

    logic                w_slot_re, w_slot_we, w_map_re, w_map_we;
    logic [AW-1:0]       w_slot_ra, w_slot_wa;
    logic [SDW-1:0]      w_slot_wd, w_slot_rd;
    logic [MAW-1:0]      w_map_ra, w_map_wa;
    logic [MDW-1:0]      w_map_wd, w_map_rd;

    logic                w_acc;
    logic [KEY_WIDTH+30:0] w_key_wide;
    logic [KEY_WIDTH-1:0] w_in_key;
    logic [CW:0]         w_pos_ext, w_left, w_right, w_count_ext;
    logic                w_has_left, w_has_right;
    logic [AW-1:0]       w_parent, w_last;
    logic [CW-1:0]       w_count_m1;
    logic                w_map_p;
    logic [AW-1:0]       w_map_s;
    logic [VW-1:0]       w_rd_v, w_mov_v, w_best_v;
    logic [KEY_WIDTH-1:0] w_rd_k, w_mov_k, w_best_k;
    logic                w_full, w_s_out;
    logic                w_out_free;
    logic [KEY_WIDTH+30:0] w_okey_wide;
    logic [CW+10:0]      w_cnt_wide;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_clr_busy;

    assign w_key_wide = {{KEY_WIDTH{1'b0}}, i_priority_key};
    assign w_in_key   = w_key_wide[KEY_WIDTH-1:0];

    assign w_pos_ext   = {{(CW+1-AW){1'b0}}, r_pos};
    assign w_count_ext = {1'b0, r_count};
    assign w_left      = (w_pos_ext << 1) + (CW+1)'(1);
    assign w_right     = w_left + (CW+1)'(1);
    assign w_has_left  = w_left < w_count_ext;
    assign w_has_right = w_right < w_count_ext;
    assign w_parent    = (r_pos - AW'(1)) >> 1;
    assign w_count_m1  = r_count - CW'(1);
    assign w_last      = w_count_m1[AW-1:0];
    assign w_full      = r_count == CW'(CAPACITY);

    assign w_map_p = w_map_rd[AW];
    assign w_map_s = w_map_rd[AW-1:0];
    assign w_s_out = {{(CW-AW){1'b0}}, w_map_s} >= r_count;

    assign w_rd_v   = w_slot_rd[SDW-1 -: VW];
    assign w_rd_k   = w_slot_rd[CSW +: KEY_WIDTH];
    assign w_mov_v  = r_mov[SDW-1 -: VW];
    assign w_mov_k  = r_mov[CSW +: KEY_WIDTH];
    assign w_best_v = r_best[SDW-1 -: VW];
    assign w_best_k = r_best[CSW +: KEY_WIDTH];

    assign w_out_free = !o_out_valid || !i_out_stall;

    imh_ram #(.DEPTH(CAPACITY), .DATA_W(SDW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_re    (w_slot_re),
        .i_raddr (w_slot_ra),
        .o_rdata (w_slot_rd),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_wa),
        .i_wdata (w_slot_wd)
    );

    imh_ram #(.DEPTH(imh_pkg::VERTEX_CNT), .DATA_W(MDW)) u_map_ram (
        .i_clk   (i_clk),
        .i_re    (w_map_re),
        .i_raddr (w_map_ra),
        .o_rdata (w_map_rd),
        .i_we    (w_map_we),
        .i_waddr (w_map_wa),
        .i_wdata (w_map_wd)
    );

    // memory port control
    always_comb begin
        w_slot_re = 1'b0;
        w_slot_ra = '0;
        w_slot_we = 1'b0;
        w_slot_wa = r_pos;
        w_slot_wd = r_mov;
        w_map_re  = 1'b0;
        w_map_ra  = i_vertex_id;
        w_map_we  = 1'b0;
        w_map_wa  = w_mov_v;
        w_map_wd  = {1'b1, r_pos};
        unique case (r_state)
            S_IDLE: begin
                if (r_clr_busy) begin
                    w_map_we = 1'b1;
                    w_map_wa = r_clr_idx;
                    w_map_wd = '0;
                end else if (w_acc) begin
                    if (i_req_type == imh_pkg::REQ_INSERT
                        || i_req_type == imh_pkg::REQ_DECREASE) begin
                        w_map_re = 1'b1;
                    end else if (i_req_type == imh_pkg::REQ_EXTRACT && r_count != '0) begin
                        w_slot_re = 1'b1;
                    end
                end
            end
            S_MAP: begin
                w_slot_ra = w_map_s;
                w_slot_re = (r_type == imh_pkg::REQ_DECREASE) && w_map_p && !w_s_out;
            end
            S_UP: begin
                w_slot_ra = w_parent;
                w_slot_re = r_pos != '0;
            end
            S_UPCHK: begin
                if (w_mov_k < w_rd_k) begin
                    w_slot_we = 1'b1;
                    w_slot_wd = w_slot_rd;
                    w_map_we  = 1'b1;
                    w_map_wa  = w_rd_v;
                end
            end
            S_ROOT: begin
                w_map_we  = 1'b1;
                w_map_wa  = w_rd_v;
                w_map_wd  = '0;
                w_slot_ra = w_last;
                w_slot_re = w_last != '0;
            end
            S_DN: begin
                w_slot_ra = w_left[AW-1:0];
                w_slot_re = w_has_left;
            end
            S_DNL: begin
                w_slot_ra = w_right[AW-1:0];
                w_slot_re = w_has_right;
            end
            S_DNMV: begin
                if (r_best_idx != r_pos) begin
                    w_slot_we = 1'b1;
                    w_slot_wd = r_best;
                    w_map_we  = 1'b1;
                    w_map_wa  = w_best_v;
                end
            end
            S_PLACE: begin
                w_slot_we = 1'b1;
                w_map_we  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_count    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (r_clr_busy) begin
                        r_clr_idx <= r_clr_idx + MAW'(1);
                        if (r_clr_idx == MAW'(imh_pkg::VERTEX_CNT - 1)) begin
                            r_clr_busy <= 1'b0;
                        end
                    end else if (w_acc) begin
                        if (i_req_type == imh_pkg::REQ_INSERT
                            || i_req_type == imh_pkg::REQ_DECREASE) begin
                            r_state <= S_MAP;
                        end else if (i_req_type == imh_pkg::REQ_EXTRACT && r_count != '0) begin
                            r_state <= S_ROOT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MAP: begin
                    if (r_type == imh_pkg::REQ_INSERT && w_map_p) begin
                        r_state <= S_DONE;
                    end else if (!w_map_p) begin
                        if (w_full) begin
                            r_state <= S_DONE;
                        end else begin
                            r_count <= r_count + CW'(1);
                            r_state <= S_UP;
                        end
                    end else if (w_s_out) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_state <= (r_key < w_rd_k) ? S_UP : S_DONE;
                end
                S_UP: begin
                    r_state <= (r_pos != '0) ? S_UPCHK : S_PLACE;
                end
                S_UPCHK: begin
                    r_state <= (w_mov_k < w_rd_k) ? S_UP : S_PLACE;
                end
                S_ROOT: begin
                    r_count <= w_count_m1;
                    r_state <= (w_last != '0) ? S_LAST : S_DONE;
                end
                S_LAST: begin
                    r_state <= S_DN;
                end
                S_DN: begin
                    r_state <= w_has_left ? S_DNL : S_PLACE;
                end
                S_DNL: begin
                    r_state <= w_has_right ? S_DNR : S_DNMV;
                end
                S_DNR: begin
                    r_state <= S_DNMV;
                end
                S_DNMV: begin
                    r_state <= (r_best_idx != r_pos) ? S_DN : S_PLACE;
                end
                S_PLACE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_type       <= i_req_type;
                    r_vid        <= i_vertex_id;
                    r_key        <= w_in_key;
                    r_cost       <= i_entry_cost;
                    r_res_status <= imh_pkg::ST_OK;
                    r_res_vertex <= '0;
                    r_res_key    <= '0;
                    r_res_cost   <= '0;
                    if (i_req_type == imh_pkg::REQ_EXTRACT && r_count == '0) begin
                        r_res_status <= imh_pkg::ST_EMPTY;
                        r_res_key    <= '1;
                        r_res_cost   <= imh_pkg::COST_EMPTY;
                    end
                end
            end
            S_MAP: begin
                r_mov <= {r_vid, r_key, r_cost};
                if (r_type == imh_pkg::REQ_INSERT && w_map_p) begin
                    r_res_status <= imh_pkg::ST_DUPLICATE;
                end else if (!w_map_p) begin
                    if (w_full) begin
                        r_res_status <= imh_pkg::ST_FULL;
                    end else begin
                        r_pos <= r_count[AW-1:0];
                    end
                end else if (w_s_out) begin
                    r_res_status <= imh_pkg::ST_NOT_SMALLER;
                end else begin
                    r_pos <= w_map_s;
                end
            end
            S_DEC: begin
                if (!(r_key < w_rd_k)) begin
                    r_res_status <= imh_pkg::ST_NOT_SMALLER;
                end
            end
            S_UPCHK: begin
                if (w_mov_k < w_rd_k) begin
                    r_pos <= w_parent;
                end
            end
            S_ROOT: begin
                r_res_vertex <= w_rd_v;
                r_res_key    <= w_rd_k;
                r_res_cost   <= w_slot_rd[CSW-1:0];
            end
            S_LAST: begin
                r_mov <= w_slot_rd;
                r_pos <= '0;
            end
            S_DNL: begin
                // left child first, only a strictly smaller key wins
                if (w_rd_k < w_mov_k) begin
                    r_best     <= w_slot_rd;
                    r_best_idx <= w_left[AW-1:0];
                end else begin
                    r_best     <= r_mov;
                    r_best_idx <= r_pos;
                end
            end
            S_DNR: begin
                if (w_rd_k < w_best_k) begin
                    r_best     <= w_slot_rd;
                    r_best_idx <= w_right[AW-1:0];
                end
            end
            S_DNMV: begin
                r_pos <= r_best_idx;
            end
            default: begin
            end
        endcase
    end

    assign w_okey_wide = {31'd0, r_res_key};
    assign w_cnt_wide  = {11'd0, r_count};

    // output word register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            o_status      <= r_res_status;
            o_min_vertex  <= r_res_vertex;
            o_min_key     <= w_okey_wide[30:0];
            o_min_cost    <= r_res_cost;
            o_entry_count <= w_cnt_wide[10:0];
        end
    end

endmodule
`default_nettype wire
